// File: hdl/alt_pkg.sv
`timescale 1ns / 1ps
package alt_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_TOKEN = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  token_start;
    logic [6:0]  token_length;
    logic        eol;
    logic [6:0]  line_length;
    logic        line_too_long;
    logic [15:0] line_no;
    logic        error_seen;
  } res_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic ACT_TOKEN   = 1'b1;
  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_TOKEN  = 1'b1;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  localparam logic [15:0] LINES_MAX = 16'hFFFF;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

// File: hdl/assembly_line_tokenizer_top.sv
`timescale 1ns / 1ps
// Assembler source line lexer.
// Input channel (in_valid / in_stall): each beat is a character push
// (in_action 0, in_last_char marks the line's final byte) or a token
// request (in_action 1). Output channel (out_valid / out_stall): one beat
// per line close (line status) and one per token request (token answer);
// plain pushes give no beat.
// Beats enter a 4-entry command queue; the executor drains it in order.
// The executor handles a push or a line close directly in S_IDLE; a
// line status passes through the command queue and the output register.
// A token request scans the line store one byte per cycle: it skips
// leading blanks, then walks the token until a byte ends it; an opening
// bracket is kept as the token's last byte. A quoted token runs to the
// line's last quote. The result beat is registered when the scan ends.
// The single read port of the line store sets this pace.
// Reset clears counters, flags and the queue; the line store needs no
// clearing. A stalled output holds its beat; pushes keep executing, the
// next command with a result waits, and once the queue is full in_stall
// rises.
module assembly_line_tokenizer_top #(
  parameter int LINE_MAX = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [6:0]  out_token_start,
  output logic [6:0]  out_token_length,
  output logic        out_eol,
  output logic [6:0]  out_line_length,
  output logic        out_line_too_long,
  output logic [15:0] out_line_no,
  output logic        out_error_seen
);

  logic          q_push, q_full, q_pop, q_empty;
  alt_pkg::cmd_t q_wcmd, q_rcmd;
  alt_pkg::res_t res;

  alt_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_wcmd)
  );

  alt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .empty (q_empty)
  );

  alt_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_rcmd),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_result_kind   = res.result_kind;
  assign out_token_start   = res.token_start;
  assign out_token_length  = res.token_length;
  assign out_eol           = res.eol;
  assign out_line_length   = res.line_length;
  assign out_line_too_long = res.line_too_long;
  assign out_line_no       = res.line_no;
  assign out_error_seen    = res.error_seen;

endmodule

// File: hdl/alt_front.sv
`timescale 1ns / 1ps
module alt_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic [7:0]    in_char_code,
  input  logic          in_last_char,
  input  logic          q_full,
  output logic          q_push,
  output alt_pkg::cmd_t q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.ch = in_char_code;
    if (in_action == alt_pkg::ACT_TOKEN) begin
      q_cmd.op = alt_pkg::OP_TOKEN;
    end else if (in_last_char) begin
      q_cmd.op = alt_pkg::OP_CLOSE;
    end else begin
      q_cmd.op = alt_pkg::OP_PUSH;
    end
  end

endmodule

// File: hdl/alt_queue.sv
`timescale 1ns / 1ps
module alt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  alt_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output alt_pkg::cmd_t rdata,
  output logic          empty
);

  localparam logic [alt_pkg::QAW:0] DEPTH_C = (alt_pkg::QAW + 1)'(alt_pkg::QDEPTH);

  alt_pkg::cmd_t             mem_r [alt_pkg::QDEPTH];
  logic [alt_pkg::QAW-1:0]   wp_r, wp_nxt;
  logic [alt_pkg::QAW-1:0]   rp_r, rp_nxt;
  logic [alt_pkg::QAW:0]     cnt_r, cnt_nxt;
  logic                      push_ok, pop_ok;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop_ok ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// File: hdl/alt_back.sv
`timescale 1ns / 1ps
module alt_back #(
  parameter int LINE_MAX = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  alt_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          out_stall,
  output logic          out_valid,
  output alt_pkg::res_t out_res
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);
  localparam logic [CW-1:0] MAX_C  = CW'(LINE_MAX);
  localparam logic [CW-1:0] LAST_C = CW'(LINE_MAX - 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SKIP = 3'b010,
    S_TOK  = 3'b100
  } state_t;

  logic [7:0]    store_r [LINE_MAX];
  logic [7:0]    rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  state_t        state_r, state_nxt;
  logic [CW-1:0] chars_r, chars_nxt;
  logic [CW-1:0] run_len_r, run_len_nxt;
  logic          run_qv_r, run_qv_nxt;
  logic [AW-1:0] run_q_r, run_q_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          qv_r, qv_nxt;
  logic [AW-1:0] q_r, q_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [15:0]   lines_r, lines_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  alt_pkg::res_t out_res_r, out_res_nxt;

  alt_pkg::res_t res;
  logic          res_fire;
  logic          load_ok;
  logic          ch_blank, ch_quote, store_ok, too_long;
  logic [CW-1:0] chars_inc;
  logic          fin;
  logic [CW-1:0] fin_n, fin_scan, end_i, q_ext;

  assign load_ok   = !out_valid_r || !out_stall;
  assign ch_blank  = alt_pkg::is_blank(q_cmd.ch);
  assign ch_quote  = (q_cmd.ch == alt_pkg::CH_QUOTE);
  assign store_ok  = (chars_r < MAX_C);
  assign chars_inc = chars_r + ONE_C;
  assign too_long  = (chars_r >= LAST_C);
  assign q_ext     = CW'(q_r);
  assign wr_addr   = chars_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    chars_nxt   = chars_r;
    run_len_nxt = run_len_r;
    run_qv_nxt  = run_qv_r;
    run_q_nxt   = run_q_r;
    len_nxt     = len_r;
    qv_nxt      = qv_r;
    q_nxt       = q_r;
    scan_nxt    = scan_r;
    idx_nxt     = idx_r;
    start_nxt   = start_r;
    n_nxt       = n_r;
    lines_nxt   = lines_r;
    err_nxt     = err_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    res_fire    = 1'b0;
    res         = '0;
    fin         = 1'b0;
    fin_n       = n_r;
    fin_scan    = idx_r;
    end_i       = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            alt_pkg::OP_PUSH: begin
              q_pop = 1'b1;
              if (store_ok) begin
                wr_en     = 1'b1;
                chars_nxt = chars_inc;
                if (!ch_blank) begin
                  run_len_nxt = chars_inc;
                end
                if (ch_quote) begin
                  run_qv_nxt = 1'b1;
                  run_q_nxt  = chars_r[AW-1:0];
                end
              end
            end
            alt_pkg::OP_CLOSE: begin
              if (load_ok) begin
                q_pop       = 1'b1;
                wr_en       = store_ok;
                chars_nxt   = '0;
                scan_nxt    = '0;
                run_len_nxt = '0;
                run_qv_nxt  = 1'b0;
                if (too_long) begin
                  len_nxt = '0;
                  qv_nxt  = 1'b0;
                  err_nxt = 1'b1;
                end else begin
                  len_nxt = ch_blank ? run_len_r : chars_inc;
                  qv_nxt  = run_qv_r || ch_quote;
                  q_nxt   = ch_quote ? chars_r[AW-1:0] : run_q_r;
                  if (lines_r != alt_pkg::LINES_MAX) begin
                    lines_nxt = lines_r + 16'd1;
                  end
                end
                res_fire          = 1'b1;
                res.result_kind   = alt_pkg::KIND_LINE;
                res.line_length   = 7'(len_nxt);
                res.line_too_long = too_long;
                res.line_no       = lines_nxt;
                res.error_seen    = err_nxt;
              end
            end
            alt_pkg::OP_TOKEN: begin
              if (chars_r != '0) begin
                if (load_ok) begin
                  q_pop           = 1'b1;
                  res_fire        = 1'b1;
                  res.result_kind = alt_pkg::KIND_TOKEN;
                  res.token_start = 7'(scan_r);
                  res.eol         = 1'b1;
                  res.line_length = 7'(len_r);
                  res.line_no     = lines_r;
                  res.error_seen  = err_r;
                end
              end else begin
                q_pop     = 1'b1;
                idx_nxt   = scan_r;
                state_nxt = S_SKIP;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_SKIP: begin
        priority if (idx_r >= len_r) begin
          if (load_ok) begin
            res_fire        = 1'b1;
            res.result_kind = alt_pkg::KIND_TOKEN;
            res.token_start = 7'(idx_r);
            res.eol         = 1'b1;
            res.line_length = 7'(len_r);
            res.line_no     = lines_r;
            res.error_seen  = err_r;
            scan_nxt        = idx_r;
            state_nxt       = S_IDLE;
          end
        end else if (alt_pkg::is_blank(rdata_r)) begin
          idx_nxt = idx_r + ONE_C;
        end else begin
          start_nxt = idx_r;
          n_nxt     = '0;
          state_nxt = S_TOK;
        end
      end
      S_TOK: begin
        priority if (idx_r >= len_r || alt_pkg::is_blank(rdata_r)) begin
          fin = 1'b1;
        end else if (rdata_r == alt_pkg::CH_LBRACK) begin
          fin      = 1'b1;
          fin_n    = n_r + ONE_C;
          fin_scan = idx_r + ONE_C;
        end else if (rdata_r == alt_pkg::CH_QUOTE && n_r == '0) begin
          fin      = 1'b1;
          end_i    = (qv_r && q_ext > idx_r) ? q_ext : idx_r;
          fin_n    = end_i - idx_r + ONE_C;
          fin_scan = end_i + ONE_C;
        end else if (rdata_r == alt_pkg::CH_COMMA || rdata_r == alt_pkg::CH_RBRACK ||
                     rdata_r == alt_pkg::CH_EQ) begin
          fin = 1'b1;
          if (n_r == '0) begin
            fin_n    = ONE_C;
            fin_scan = idx_r + ONE_C;
          end
        end else begin
          idx_nxt = idx_r + ONE_C;
          n_nxt   = n_r + ONE_C;
        end
        if (fin && load_ok) begin
          res_fire         = 1'b1;
          res.result_kind  = alt_pkg::KIND_TOKEN;
          res.token_start  = 7'(start_r);
          res.token_length = 7'(fin_n);
          res.line_length  = 7'(len_r);
          res.line_no      = lines_r;
          res.error_seen   = err_r;
          scan_nxt         = fin_scan;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_addr = (state_r == S_IDLE) ? scan_r[AW-1:0] : idx_nxt[AW-1:0];

    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chars_r     <= '0;
      run_len_r   <= '0;
      run_qv_r    <= 1'b0;
      len_r       <= '0;
      qv_r        <= 1'b0;
      scan_r      <= '0;
      idx_r       <= '0;
      start_r     <= '0;
      n_r         <= '0;
      lines_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chars_r     <= chars_nxt;
      run_len_r   <= run_len_nxt;
      run_qv_r    <= run_qv_nxt;
      len_r       <= len_nxt;
      qv_r        <= qv_nxt;
      scan_r      <= scan_nxt;
      idx_r       <= idx_nxt;
      start_r     <= start_nxt;
      n_r         <= n_nxt;
      lines_r     <= lines_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_q_r   <= run_q_nxt;
    q_r       <= q_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= q_cmd.ch;
    end
    rdata_r <= store_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: hdl/alt_checker.sv
`timescale 1ns / 1ps
module alt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [6:0]  out_token_start,
  input logic [6:0]  out_token_length,
  input logic        out_eol,
  input logic        out_line_too_long,
  input logic        out_error_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  a_long_sets_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_too_long |-> out_error_seen && !out_result_kind)
    else $error("too-long line without sticky error");

  a_eol_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind && out_eol |-> out_token_length == 7'd0)
    else $error("end of line with nonzero token length");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |->
      out_token_start == 7'd0 && out_token_length == 7'd0 && !out_eol)
    else $error("line status carries token fields");

endmodule

bind assembly_line_tokenizer_top alt_checker u_alt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_kind   (out_result_kind),
  .out_token_start   (out_token_start),
  .out_token_length  (out_token_length),
  .out_eol           (out_eol),
  .out_line_too_long (out_line_too_long),
  .out_error_seen    (out_error_seen)
);
